@@ rtl/htmd_pkg.sv @@
// Shared types, widths and constants for the heading-to-motor-drive block.
`timescale 1ns / 1ps
package htmd_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS    = 16;
  // Magnitude of a sample, then scaled by 2^16, plus CORDIC growth and sign.
  localparam int MAG_W = SAMPLE_BITS + 1;
  localparam int XW    = MAG_W + FRAC_BITS + 5;
  localparam int ZW    = 25;
  localparam int AW    = 24;

  localparam logic [ZW-1:0] Z_90  = ZW'(90 * 65536);
  localparam logic [AW-1:0] A_90  = AW'(90 * 65536);
  localparam logic [AW-1:0] A_180 = AW'(180 * 65536);

  typedef logic signed [XW-1:0] cord_t;
  typedef logic signed [ZW-1:0] ang_t;

  // Sideband carried alongside the rotation stages.
  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic origin;
    logic on_axis;
  } htmd_side_t;

  typedef enum logic [7:0] {
    REG_SPEED_GAIN = 8'd0,
    REG_MIN_SPEED  = 8'd1,
    REG_MAX_SPEED  = 8'd2,
    REG_STOP_BAND  = 8'd3
  } htmd_reg_t;

  // round(atan(2^-i) * 180/pi * 65536)
  function automatic ang_t htmd_atan(input int idx);
    logic [22:0] v;
    begin
      case (idx)
        0:  v = 23'd2949120;
        1:  v = 23'd1740967;
        2:  v = 23'd919879;
        3:  v = 23'd466945;
        4:  v = 23'd234379;
        5:  v = 23'd117304;
        6:  v = 23'd58666;
        7:  v = 23'd29335;
        8:  v = 23'd14668;
        9:  v = 23'd7334;
        10: v = 23'd3667;
        11: v = 23'd1833;
        12: v = 23'd917;
        13: v = 23'd458;
        14: v = 23'd229;
        15: v = 23'd115;
        16: v = 23'd57;
        17: v = 23'd29;
        18: v = 23'd14;
        19: v = 23'd7;
        20: v = 23'd4;
        21: v = 23'd2;
        22: v = 23'd1;
        default: v = 23'd0;
      endcase
      htmd_atan = ang_t'({2'b00, v});
    end
  endfunction

endpackage

@@ rtl/htmd_cordic.sv @@
// Unrolled CORDIC vectoring pipeline, one rotation per register stage.
`timescale 1ns / 1ps
module htmd_cordic
  import htmd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic       in_valid,
  input  cord_t      in_x,
  input  cord_t      in_y,
  input  htmd_side_t in_side,
  output logic       out_valid,
  output ang_t       out_z,
  output htmd_side_t out_side
);

  localparam int STEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

  logic       vld_r  [STEPS];
  cord_t      x_r    [STEPS];
  cord_t      y_r    [STEPS];
  ang_t       z_r    [STEPS];
  htmd_side_t side_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic       vld_in;
    cord_t      x_in;
    cord_t      y_in;
    ang_t       z_in;
    htmd_side_t side_in;
    cord_t      x_nxt;
    cord_t      y_nxt;
    ang_t       z_nxt;

    if (i == 0) begin : g_first
      assign vld_in  = in_valid;
      assign x_in    = in_x;
      assign y_in    = in_y;
      assign z_in    = '0;
      assign side_in = in_side;
    end else begin : g_rest
      assign vld_in  = vld_r[i-1];
      assign x_in    = x_r[i-1];
      assign y_in    = y_r[i-1];
      assign z_in    = z_r[i-1];
      assign side_in = side_r[i-1];
    end

    // Rotate toward y = 0; hold when y is already zero.
    always_comb begin
      x_nxt = x_in;
      y_nxt = y_in;
      z_nxt = z_in;
      if (y_in > 0) begin
        x_nxt = x_in + (y_in >>> i);
        y_nxt = y_in - (x_in >>> i);
        z_nxt = z_in + htmd_atan(i);
      end else if (y_in < 0) begin
        x_nxt = x_in - (y_in >>> i);
        y_nxt = y_in + (x_in >>> i);
        z_nxt = z_in - htmd_atan(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (adv) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[i]    <= x_nxt;
        y_r[i]    <= y_nxt;
        z_r[i]    <= z_nxt;
        side_r[i] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[STEPS-1];
  assign out_z     = z_r[STEPS-1];
  assign out_side  = side_r[STEPS-1];

endmodule

@@ rtl/heading_to_motor_drive.sv @@
// Top level: magnetometer sample to heading and motor drive command.
`timescale 1ns / 1ps
// Pipeline from input request to result request: 1 capture stage, 16 CORDIC
// rotation stages, angle fold, gain multiply, clamp/output register.
// Throughput: one request per cycle; the whole pipeline advances when the output
// register is empty or being taken, so a stall holds every stage in place.
// Reset (rst_n low, synchronous) empties all stages and loads the register
// defaults: gain 384, min speed 0, max speed 100, stop band 1.
module heading_to_motor_drive
  import htmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] mag_x, [31:16] mag_y
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [8:0] heading_deg, [16:9] drive_speed,
                                  // [17] turn_right, [18] stopping, rest zero
  // Register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers; writes are always taken
  // ---------------------------------------------------------------------------
  logic [9:0] speed_gain_r;
  logic [7:0] min_speed_r;
  logic [7:0] max_speed_r;
  logic [7:0] stop_band_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_gain_r <= 10'd384;
      min_speed_r  <= 8'd0;
      max_speed_r  <= 8'd100;
      stop_band_r  <= 8'd1;
    end else if (cfg_valid) begin
      case (htmd_reg_t'(cfg_index))
        REG_SPEED_GAIN: speed_gain_r <= cfg_data;
        REG_MIN_SPEED:  min_speed_r  <= cfg_data[7:0];
        REG_MAX_SPEED:  max_speed_r  <= cfg_data[7:0];
        REG_STOP_BAND:  stop_band_r  <= cfg_data[7:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance: move everything when the output slot frees up
  // ---------------------------------------------------------------------------
  logic adv;
  logic out_vld_r;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  // ---------------------------------------------------------------------------
  // Stage A: capture, take magnitudes, note quadrant and special cases
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] mag_x;
  logic signed [SAMPLE_BITS-1:0] mag_y;
  logic [MAG_W-1:0] ax_nxt;
  logic [MAG_W-1:0] ay_nxt;
  logic [MAG_W-1:0] ax_r;
  logic [MAG_W-1:0] ay_r;
  htmd_side_t       side_nxt;
  htmd_side_t       side_a_r;
  logic             vld_a_r;

  assign mag_x = in_tdata[15:0];
  assign mag_y = in_tdata[31:16];

  always_comb begin
    ax_nxt = mag_x[SAMPLE_BITS-1] ? MAG_W'(-{mag_x[SAMPLE_BITS-1], mag_x})
                                  : MAG_W'({1'b0, mag_x});
    ay_nxt = mag_y[SAMPLE_BITS-1] ? MAG_W'(-{mag_y[SAMPLE_BITS-1], mag_y})
                                  : MAG_W'({1'b0, mag_y});
    side_nxt.x_neg   = mag_x[SAMPLE_BITS-1];
    side_nxt.y_neg   = mag_y[SAMPLE_BITS-1];
    side_nxt.on_axis = (mag_x == '0);
    side_nxt.origin  = (mag_x == '0) && (mag_y == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (adv) begin
      vld_a_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r     <= ax_nxt;
      ay_r     <= ay_nxt;
      side_a_r <= side_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // CORDIC rotations on magnitudes scaled by 2^16 (first quadrant only)
  // ---------------------------------------------------------------------------
  cord_t      cx;
  cord_t      cy;
  logic       cord_vld;
  ang_t       cord_z;
  htmd_side_t cord_side;

  assign cx = cord_t'({ax_r, {FRAC_BITS{1'b0}}});
  assign cy = cord_t'({ay_r, {FRAC_BITS{1'b0}}});

  htmd_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (vld_a_r),
    .in_x      (cx),
    .in_y      (cy),
    .in_side   (side_a_r),
    .out_valid (cord_vld),
    .out_z     (cord_z),
    .out_side  (cord_side)
  );

  // ---------------------------------------------------------------------------
  // Stage B: clamp to [0, 90], fold into the proper half, truncate to degrees
  // ---------------------------------------------------------------------------
  logic [AW-1:0] q1_ang;
  logic [AW-1:0] full_ang;
  logic [7:0]    deg_mag_nxt;
  logic [7:0]    deg_mag_r;
  logic          neg_nxt;
  logic          neg_b_r;
  logic          vld_b_r;

  always_comb begin
    if (cord_side.on_axis) begin
      q1_ang = A_90;
    end else if (cord_z < 0) begin
      q1_ang = '0;
    end else if (cord_z > $signed(Z_90)) begin
      q1_ang = A_90;
    end else begin
      q1_ang = cord_z[AW-1:0];
    end
    full_ang    = cord_side.x_neg ? (A_180 - q1_ang) : q1_ang;
    deg_mag_nxt = cord_side.origin ? 8'd0 : full_ang[AW-1:FRAC_BITS];
    neg_nxt     = cord_side.y_neg && (deg_mag_nxt != 8'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else if (adv) begin
      vld_b_r <= cord_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      deg_mag_r <= deg_mag_nxt;
      neg_b_r   <= neg_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: apply gain (Q8), signed heading, stop-band test
  // ---------------------------------------------------------------------------
  logic [17:0]       prod;
  logic [9:0]        spd_raw_r;
  logic signed [8:0] deg_nxt;
  logic signed [8:0] deg_c_r;
  logic              neg_c_r;
  logic              stop_c_r;
  logic              vld_c_r;

  assign prod    = 18'(deg_mag_r) * 18'(speed_gain_r);
  assign deg_nxt = neg_b_r ? -$signed({1'b0, deg_mag_r}) : $signed({1'b0, deg_mag_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
    end else if (adv) begin
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      spd_raw_r <= prod[17:8];
      deg_c_r   <= deg_nxt;
      neg_c_r   <= neg_b_r;
      stop_c_r  <= (deg_mag_r < stop_band_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: speed clamp (max checked first), stop override, output
  // ---------------------------------------------------------------------------
  logic [7:0]        spd_nxt;
  logic [7:0]        spd_r;
  logic signed [8:0] deg_r;
  logic              right_r;
  logic              stop_r;

  always_comb begin
    if (spd_raw_r > {2'b00, max_speed_r}) begin
      spd_nxt = max_speed_r;
    end else if (spd_raw_r < {2'b00, min_speed_r}) begin
      spd_nxt = min_speed_r;
    end else begin
      spd_nxt = spd_raw_r[7:0];
    end
    if (stop_c_r) begin
      spd_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= vld_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      spd_r   <= spd_nxt;
      deg_r   <= deg_c_r;
      right_r <= !neg_c_r && !stop_c_r;
      stop_r  <= stop_c_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, stop_r, right_r, spd_r, deg_r};

endmodule
